FILE: rtl/linear_tone_sweep_generator_top_assert.svh
// Assertion macros for the tone sweep generator checker.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef LINEAR_TONE_SWEEP_GENERATOR_TOP_ASSERT_SVH
`define LINEAR_TONE_SWEEP_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication
`define LTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LTS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lts_pkg.sv
// Shared types, constants and helpers of the tone sweep generator.
// No dependencies.
package lts_pkg;

    localparam int FIELD_W   = 16;
    localparam int FREQ_W    = 15;
    localparam int CLK_W     = 22;
    localparam int ITER_W    = 5;

    localparam logic [FREQ_W-1:0] FREQ_MIN  = 15'd20;
    localparam logic [FREQ_W-1:0] FREQ_MAX  = 15'd20000;
    localparam logic [CLK_W-1:0]  CLK_RESET = 22'd1193182;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // quotient bits of the two divisions
    localparam logic [ITER_W-1:0] STEP_ITERS = 5'd15;
    localparam logic [ITER_W-1:0] CLK_ITERS  = 5'd22;

    typedef struct packed {
        logic               req_type;
        logic [FIELD_W-1:0] freq_from;
        logic [FIELD_W-1:0] freq_to;
        logic [FIELD_W-1:0] sweep_len;
    } t_req;

    typedef struct packed {
        logic               speaker_on;
        logic [FREQ_W-1:0]  tone_freq;
        logic [FIELD_W-1:0] timer_divisor;
        logic               sweep_done;
    } t_rsp;

    typedef struct packed {
        logic              start;
        logic [ITER_W-1:0] iters;
    } t_div_cmd;

    function automatic logic [FREQ_W-1:0] clamp_freq(input logic [FIELD_W-1:0] f);
        logic [FREQ_W-1:0] r;
        if (f < FIELD_W'(FREQ_MIN)) begin
            r = FREQ_MIN;
        end else if (f > FIELD_W'(FREQ_MAX)) begin
            r = FREQ_MAX;
        end else begin
            r = f[FREQ_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/lts_mul.sv
// Bit-serial shift-add multiplier: span times elapsed, one multiplier bit per cycle.
// Uses lts_pkg.
module lts_mul #(
    parameter int MW = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [lts_pkg::FREQ_W-1:0]     i_span,
    input  logic [MW-1:0]                  i_mplr,
    output logic                           o_done,
    output logic [lts_pkg::FREQ_W+MW-1:0]  o_prod
);

    localparam int CW = $clog2(MW + 1);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [CW-1:0]                 r_cnt, n_cnt;
    logic [lts_pkg::FREQ_W-1:0]    r_span;
    logic [lts_pkg::FREQ_W-1:0]    r_hi;
    logic [MW-1:0]                 r_lo;
    logic [lts_pkg::FREQ_W:0]      w_sum;

    // add span into the high half when the current multiplier bit is set
    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_span} : '0);

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(MW);
        end else if (r_busy) begin
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_span <= i_span;
            r_hi   <= '0;
            r_lo   <= i_mplr;
        end else if (r_busy) begin
            r_hi <= w_sum[lts_pkg::FREQ_W:1];
            r_lo <= {w_sum[0], r_lo[MW-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule

FILE: rtl/lts_div.sv
// Restoring divider, one quotient bit per cycle; shared by both divisions.
// Uses lts_pkg.
module lts_div #(
    parameter int DW = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lts_pkg::t_div_cmd           i_cmd,
    input  logic [DW-1:0]               i_rem,
    input  logic [lts_pkg::CLK_W-1:0]   i_dvd,
    input  logic [DW-1:0]               i_dsr,
    output logic                        o_done,
    output logic [lts_pkg::CLK_W-1:0]   o_quo
);

    logic                              r_busy, n_busy;
    logic                              r_done, n_done;
    logic [lts_pkg::ITER_W-1:0]        r_cnt, n_cnt;
    logic [DW-1:0]                     r_rem;
    logic [DW-1:0]                     r_dsr;
    logic [lts_pkg::CLK_W-1:0]         r_dvd;
    logic [DW:0]                       w_trial;
    logic                              w_fit;
    logic [DW:0]                       w_diff;

    // bring down the next dividend bit, subtract when it fits
    assign w_trial = {r_rem, r_dvd[lts_pkg::CLK_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_dsr};
    assign w_diff  = w_trial - {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_cmd.start) begin
            n_busy = 1'b1;
            n_cnt  = i_cmd.iters;
        end else if (r_busy) begin
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == lts_pkg::ITER_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rem <= i_rem;
            r_dsr <= i_dsr;
            r_dvd <= i_dvd;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_dvd <= {r_dvd[lts_pkg::CLK_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_dvd;

endmodule

FILE: rtl/linear_tone_sweep_generator_top.sv
// Linear tone sweep generator: sweep state, control sequencer and output register.
// Uses lts_pkg, lts_mul and lts_div.
//
// A start word is taken without a stall and gives no result. A tick word that
// produces a tone holds o_stall high while it passes through the states S_MUL,
// S_DIVS, S_DIVC and S_OUT; the tone word shows on o_valid at the end of that
// stall. The bit-serial multiplier works through DURATION_BITS multiplier bits,
// the shared serial divider then makes 15 quotient bits for the sweep step and
// 22 for the timer divisor, and the output register is loaded last. A tick that
// ends the sweep stalls the input only while in S_OUT; a tick that finds the
// block inactive is taken without a stall. New words also stall while a result
// waits for the output register.
module linear_tone_sweep_generator_top #(
    parameter int DURATION_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  lts_pkg::t_req               i_data,
    output logic                        o_valid,
    input  logic                        i_stall,
    output lts_pkg::t_rsp               o_data,
    input  logic                        i_cfg_we,
    input  logic [lts_pkg::CLK_W-1:0]   i_cfg_data
);

    localparam int DB   = DURATION_BITS;
    localparam int DIVW = (DB > lts_pkg::FREQ_W) ? DB : lts_pkg::FREQ_W;
    localparam int PW   = lts_pkg::FREQ_W + DB;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIVS = 5'b00100,
        S_DIVC = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state                         r_state, n_state;
    logic                           r_active;
    logic [lts_pkg::FREQ_W-1:0]     r_from, r_to, r_freq;
    logic [DB-1:0]                  r_elapsed, r_total;
    logic [lts_pkg::CLK_W-1:0]      r_clk;
    lts_pkg::t_rsp                  r_res, r_odata;
    logic                           r_ovalid;

    logic [DB-1:0]                  w_dur;
    logic                           w_acc, w_start, w_run, w_end, w_tone;
    logic                           w_down;
    logic [lts_pkg::FREQ_W-1:0]     w_span;
    logic                           w_mul_done;
    logic [PW-1:0]                  w_prod;
    lts_pkg::t_div_cmd              w_cmd;
    logic [DIVW-1:0]                w_rem, w_dsr;
    logic [lts_pkg::CLK_W-1:0]      w_dvd;
    logic                           w_div_done;
    logic [lts_pkg::CLK_W-1:0]      w_quo;
    logic [lts_pkg::FIELD_W-1:0]    w_fsum;
    logic [lts_pkg::FREQ_W-1:0]     w_freq;
    logic [lts_pkg::FIELD_W-1:0]    w_tdiv;
    logic                           w_out_free;

    assign w_dur   = DB'(i_data.sweep_len);
    assign w_acc   = i_valid && (r_state == S_IDLE);
    assign w_start = w_acc && (i_data.req_type == lts_pkg::REQ_START) && (w_dur != '0);
    assign w_run   = w_acc && (i_data.req_type == lts_pkg::REQ_TICK) && r_active;
    assign w_end   = w_run && (r_elapsed >= r_total);
    assign w_tone  = w_run && !w_end;

    assign w_down = r_to < r_from;
    assign w_span = w_down ? (r_from - r_to) : (r_to - r_from);

    // apply the step in the sweep direction, then clamp
    assign w_fsum = w_down
        ? (lts_pkg::FIELD_W'(r_from) - lts_pkg::FIELD_W'(w_quo[lts_pkg::FREQ_W-1:0]))
        : (lts_pkg::FIELD_W'(r_from) + lts_pkg::FIELD_W'(w_quo[lts_pkg::FREQ_W-1:0]));
    assign w_freq = lts_pkg::clamp_freq(w_fsum);

    assign w_tdiv = (w_quo[lts_pkg::FIELD_W-1:0] == '0) ? lts_pkg::FIELD_W'(1)
                                                       : w_quo[lts_pkg::FIELD_W-1:0];

    assign w_out_free = !r_ovalid || !i_stall;

    lts_mul #(.MW(DB)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_tone),
        .i_span  (w_span),
        .i_mplr  (r_elapsed),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // divider feed: product / total first, then timer clock / frequency
    always_comb begin
        w_cmd.start = 1'b0;
        w_cmd.iters = lts_pkg::STEP_ITERS;
        w_rem       = DIVW'(w_prod[PW-1:lts_pkg::FREQ_W]);
        w_dvd       = {w_prod[lts_pkg::FREQ_W-1:0],
                       (lts_pkg::CLK_W - lts_pkg::FREQ_W)'(0)};
        w_dsr       = DIVW'(r_total);
        if (r_state == S_MUL) begin
            w_cmd.start = w_mul_done;
        end else if (r_state == S_DIVS) begin
            w_cmd.start = w_div_done;
            w_cmd.iters = lts_pkg::CLK_ITERS;
            w_rem       = '0;
            w_dvd       = r_clk;
            w_dsr       = DIVW'(w_freq);
        end
    end

    lts_div #(.DW(DIVW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_rem   (w_rem),
        .i_dvd   (w_dvd),
        .i_dsr   (w_dsr),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_tone) begin
                    n_state = S_MUL;
                end else if (w_end) begin
                    n_state = S_OUT;
                end
            end
            S_MUL: begin
                if (w_mul_done) begin
                    n_state = S_DIVS;
                end
            end
            S_DIVS: begin
                if (w_div_done) begin
                    n_state = S_DIVC;
                end
            end
            S_DIVC: begin
                if (w_div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_active  <= 1'b0;
            r_from    <= '0;
            r_to      <= '0;
            r_elapsed <= '0;
            r_total   <= '0;
            r_clk     <= lts_pkg::CLK_RESET;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_clk <= i_cfg_data;
            end
            if (w_start) begin
                r_from    <= lts_pkg::clamp_freq(i_data.freq_from);
                r_to      <= lts_pkg::clamp_freq(i_data.freq_to);
                r_total   <= w_dur;
                r_elapsed <= '0;
                r_active  <= 1'b1;
            end else if (w_end) begin
                r_active <= 1'b0;
            end else if (w_tone) begin
                // multiplier has latched the old count
                r_elapsed <= r_elapsed + 1'b1;
            end
            if (r_state == S_OUT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_end) begin
            r_res.speaker_on    <= 1'b0;
            r_res.tone_freq     <= '0;
            r_res.timer_divisor <= '0;
            r_res.sweep_done    <= 1'b1;
        end else if (r_state == S_DIVC && w_div_done) begin
            r_res.speaker_on    <= 1'b1;
            r_res.tone_freq     <= r_freq;
            r_res.timer_divisor <= w_tdiv;
            r_res.sweep_done    <= 1'b0;
        end
        if (r_state == S_DIVS && w_div_done) begin
            r_freq <= w_freq;
        end
        if (r_state == S_OUT && w_out_free) begin
            r_odata <= r_res;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

endmodule

FILE: rtl/lts_checker.sv
// Port-level checker for the tone sweep generator, bound to the top level.
// Uses lts_pkg and linear_tone_sweep_generator_top_assert.svh.
`include "linear_tone_sweep_generator_top_assert.svh"

module lts_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        o_stall,
    input  lts_pkg::t_req               i_data,
    input  logic                        o_valid,
    input  logic                        i_stall,
    input  lts_pkg::t_rsp               o_data
);

    logic w_off_ok;
    logic w_tone_ok;
    logic w_start_acc;

    assign w_off_ok = (o_data.tone_freq == '0) && (o_data.timer_divisor == '0)
                      && o_data.sweep_done;
    assign w_tone_ok = !o_data.sweep_done && (o_data.timer_divisor != '0)
                       && (o_data.tone_freq >= lts_pkg::FREQ_MIN)
                       && (o_data.tone_freq <= lts_pkg::FREQ_MAX);
    assign w_start_acc = i_valid && !o_stall && (i_data.req_type == lts_pkg::REQ_START);

    `LTS_ASSERT_IMP(a_off_word, o_valid && !o_data.speaker_on, w_off_ok, "bad off word")

    `LTS_ASSERT_IMP(a_tone_word, o_valid && o_data.speaker_on, w_tone_ok, "bad tone word")

    `LTS_ASSERT_NXT(a_start_quick, w_start_acc, !o_stall, "start word stalled next word")

    `LTS_ASSERT_NXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_data), "held word changed")

endmodule

bind linear_tone_sweep_generator_top lts_checker u_lts_checker (.*);

FILE: verif/testbench.sv
// Testbench for the linear tone sweep generator: directed and random sweeps, with
// result words checked against a built-in sweep predictor.
// Depends on lts_pkg and linear_tone_sweep_generator_top.
module testbench;

    localparam int DUR_BITS     = 16;
    localparam int SETTLE       = DUR_BITS + 64;
    localparam int LIMIT_CYCLES = 1000000;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    lts_pkg::t_req             in_data   = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    lts_pkg::t_rsp             rsp_out;
    logic                      cfg_we    = 1'b0;
    logic [lts_pkg::CLK_W-1:0] cfg_data  = '0;

    // predictor state
    logic [lts_pkg::CLK_W-1:0] tone_clock_hz = lts_pkg::CLK_RESET;
    logic                      sw_active     = 1'b0;
    int unsigned               sw_from       = 0;
    int unsigned               sw_to         = 0;
    int unsigned               sw_elapsed    = 0;
    int unsigned               sw_total      = 0;

    lts_pkg::t_rsp tones_due[$];
    int unsigned   useful_words = 0;
    int unsigned   failures     = 0;
    int unsigned   hold_left    = 0;
    int unsigned   stall_left   = 0;
    bit            quiet[2]     = '{1'b0, 1'b0};

    linear_tone_sweep_generator_top #(
        .DURATION_BITS(DUR_BITS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_stall    (in_stall),
        .i_data     (in_data),
        .o_valid    (out_valid),
        .i_stall    (out_stall),
        .o_data     (rsp_out),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial begin
        #(2 * LIMIT_CYCLES);
        $display("testbench NOT OK");
        $finish;
    end

    // side 0 is the sender, side 1 the receiver; each flips into quiet stretches with no pauses now and then
    function automatic int unsigned draw_pause(input int side);
        if ($urandom_range(0, 39) == 0) begin
            quiet[side] = !quiet[side];
        end
        return quiet[side] ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic int unsigned limit_freq(input int unsigned f);
        if (f < lts_pkg::FREQ_MIN) begin
            return 32'(lts_pkg::FREQ_MIN);
        end
        if (f > lts_pkg::FREQ_MAX) begin
            return 32'(lts_pkg::FREQ_MAX);
        end
        return f;
    endfunction

    function automatic void predict_sweep(input lts_pkg::t_req w);
        lts_pkg::t_rsp r;
        bit            down;
        int unsigned   span;
        int unsigned   step;
        int unsigned   f;
        int unsigned   div;
        if (w.req_type == lts_pkg::REQ_START) begin
            if (w.sweep_len != 0) begin
                sw_from    = limit_freq(32'(w.freq_from));
                sw_to      = limit_freq(32'(w.freq_to));
                sw_total   = 32'(w.sweep_len);
                sw_elapsed = 0;
                sw_active  = 1'b1;
                useful_words++;
            end
        end else if (sw_active) begin
            useful_words++;
            r = '0;
            if (sw_elapsed >= sw_total) begin
                sw_active    = 1'b0;
                r.sweep_done = 1'b1;
            end else begin
                down = sw_to < sw_from;
                span = down ? sw_from - sw_to : sw_to - sw_from;
                // span < 2^15 and elapsed < 2^16, so the product fits in 32 bits
                step = (span * sw_elapsed) / sw_total;
                f    = limit_freq(down ? sw_from - step : sw_from + step);
                div  = (tone_clock_hz / f) & 32'hFFFF;
                if (div == 0) begin
                    div = 1;
                end
                r.speaker_on    = 1'b1;
                r.tone_freq     = f[lts_pkg::FREQ_W-1:0];
                r.timer_divisor = div[15:0];
                sw_elapsed      = (sw_elapsed + 1) & 32'hFFFF;
            end
            tones_due.push_back(r);
        end
    endfunction

    function automatic lts_pkg::t_req mk_start(input int unsigned f0, input int unsigned f1,
                                               input int unsigned dur);
        lts_pkg::t_req w;
        w.req_type  = lts_pkg::REQ_START;
        w.freq_from = 16'(f0);
        w.freq_to   = 16'(f1);
        w.sweep_len = 16'(dur);
        return w;
    endfunction

    // ticks carry random junk in the unused fields
    function automatic lts_pkg::t_req mk_tick();
        lts_pkg::t_req w;
        w.req_type  = lts_pkg::REQ_TICK;
        w.freq_from = 16'($urandom);
        w.freq_to   = 16'($urandom);
        w.sweep_len = 16'($urandom);
        return w;
    endfunction

    task automatic send_word(input lts_pkg::t_req w);
        int unsigned gap;
        gap = draw_pause(0);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (in_stall);
        predict_sweep(w);
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n) send_word(mk_tick());
    endtask

    // drop valid and hold until every expected word is out
    task automatic pause_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (tones_due.size() != 0);
    endtask

    task automatic set_tone_clock(input logic [lts_pkg::CLK_W-1:0] hz);
        pause_for_results();
        repeat (SETTLE) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= hz;
        @(posedge clk);
        cfg_we        <= 1'b0;
        tone_clock_hz = hz;
    endtask

    // receiver: per-word stall draw, plus an optional long hold-off
    always @(posedge clk) begin : receiver
        int unsigned pause;
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (stall_left != 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (out_valid && !out_stall) begin
            pause      = draw_pause(1);
            stall_left <= (pause != 0) ? pause - 1 : 0;
            out_stall  <= (pause != 0);
        end else begin
            out_stall <= 1'b0;
        end
    end

    function automatic void compare_field(input string field, input int unsigned exp_v,
                                          input int unsigned act_v);
        if (exp_v != act_v) begin
            failures++;
            $display("%0t: %s expected %0d actual %0d", $time, field, exp_v, act_v);
        end
    endfunction

    always @(posedge clk) begin : result_check
        lts_pkg::t_rsp want;
        if (rst_n && out_valid && !out_stall) begin
            if (tones_due.size() == 0) begin
                failures++;
                $display("%0t: word with nothing expected, expected none actual %h",
                         $time, rsp_out);
            end else begin
                want = tones_due.pop_front();
                compare_field("speaker_on", 32'(want.speaker_on), 32'(rsp_out.speaker_on));
                compare_field("tone_freq", 32'(want.tone_freq), 32'(rsp_out.tone_freq));
                compare_field("timer_divisor", 32'(want.timer_divisor),
                              32'(rsp_out.timer_divisor));
                compare_field("sweep_done", 32'(want.sweep_done), 32'(rsp_out.sweep_done));
            end
        end
    end

    task automatic test_idle_ticks();
        send_ticks(1);
        send_word(mk_start(1000, 2000, 0));
        send_ticks(1);
    endtask

    task automatic test_clamp_extremes();
        send_word(mk_start(0, 65535, 2));
        send_ticks(4);
        send_word(mk_start(65535, 19, 1));
        send_ticks(2);
    endtask

    task automatic test_replace_running();
        send_word(mk_start(20001, 20000, 65535));
        send_ticks(1);
        send_word(mk_start(19, 20, 1));
        send_ticks(2);
    endtask

    // zero clock forces divisor 1; full clock truncates the divisor to 16 bits
    task automatic test_clock_extremes();
        set_tone_clock('0);
        send_word(mk_start(20, 20000, 1));
        send_ticks(2);
        set_tone_clock({lts_pkg::CLK_W{1'b1}});
        send_word(mk_start(20, 20000, 1));
        send_ticks(2);
        set_tone_clock(lts_pkg::CLK_W'(1));
        send_word(mk_start(20000, 20, 1));
        send_ticks(2);
    endtask

    task automatic test_backpressure();
        set_tone_clock(lts_pkg::CLK_RESET);
        hold_left <= 300;
        send_word(mk_start(20, 20000, 40));
        send_ticks(41);
        pause_for_results();
    endtask

    function automatic int unsigned pick_freq();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 19);
            1:       return 32'(lts_pkg::FREQ_MIN);
            2:       return 32'(lts_pkg::FREQ_MAX);
            3:       return $urandom_range(20001, 65535);
            4:       return $urandom & 32'hFFFF;
            default: return $urandom_range(20, 20000);
        endcase
    endfunction

    function automatic int unsigned pick_duration();
        case ($urandom_range(0, 29))
            0:       return $urandom_range(1, 65535);
            1, 2, 3: return $urandom_range(25, 200);
            default: return $urandom_range(1, 24);
        endcase
    endfunction

    task automatic test_random_sweeps(input logic [lts_pkg::CLK_W-1:0] hz,
                                      input int unsigned goal);
        int unsigned dur;
        int unsigned n;
        set_tone_clock(hz);
        while (useful_words < goal) begin
            case ($urandom_range(0, 15))
                0: send_ticks(1);
                1: send_word(mk_start($urandom, $urandom, 0));
                default: begin
                    dur = pick_duration();
                    send_word(mk_start(pick_freq(), pick_freq(), dur));
                    if (dur > 60) begin
                        n = $urandom_range(1, 40);
                    end else begin
                        case ($urandom_range(0, 7))
                            0:       n = $urandom_range(0, dur);
                            1:       n = dur + 2;
                            default: n = dur + 1;
                        endcase
                    end
                    send_ticks(n);
                end
            endcase
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_idle_ticks();
        test_clamp_extremes();
        test_replace_running();
        test_clock_extremes();
        test_backpressure();
        test_random_sweeps(lts_pkg::CLK_RESET, useful_words + 330);
        test_random_sweeps({lts_pkg::CLK_W{1'b1}}, useful_words + 330);
        test_random_sweeps(lts_pkg::CLK_W'(1), useful_words + 330);
        test_random_sweeps(lts_pkg::CLK_W'($urandom_range(1, 4194303)), useful_words + 330);
        test_random_sweeps(lts_pkg::CLK_W'(1310720), useful_words + 330);
        pause_for_results();
        repeat (SETTLE) @(posedge clk);
        if (failures == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/lts_pkg.sv
rtl/lts_mul.sv
rtl/lts_div.sv
rtl/linear_tone_sweep_generator_top.sv
rtl/lts_checker.sv
verif/testbench.sv
